@@ design/assert_macros.svh @@
// assert_macros.svh: assertion macros for the serial command framer.
// Used by the RTL modules that carry concurrent checks; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define SCF_CHECK(label, ck, rs, prop, msg) \
  label: assert property (@(posedge ck) disable iff (rs) prop) \
    else $error(msg);

// Expression must never be true outside reset.
`define SCF_NEVER(label, ck, rs, expr, msg) \
  label: assert property (@(posedge ck) disable iff (rs) !(expr)) \
    else $error(msg);

`endif

@@ design/scf_pkg.sv @@
// scf_pkg.sv: shared types and constants of the serial command framer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package scf_pkg;

  localparam int MAX_BEATS  = 10;               // longest burst per input beat
  localparam int BEAT_CNT_W = $clog2(MAX_BEATS + 1);

  localparam logic [7:0] HEAD0 = 8'hAA;
  localparam logic [7:0] HEAD1 = 8'h55;
  localparam logic [7:0] TAIL0 = 8'hCC;
  localparam logic [7:0] TAIL1 = 8'h33;
  localparam logic [9:0] FRAME_OVERHEAD = 10'd10;

  typedef enum logic {
    REQ_START = 1'b0,
    REQ_DATA  = 1'b1
  } req_type_t;

  typedef struct packed {
    req_type_t   req_type;
    logic [15:0] cmd_code;
    logic [8:0]  payload_len;
    logic [7:0]  data_byte;
  } scf_item_t;

  // Bytes produced by one input beat, byte 0 goes out first.
  typedef struct packed {
    logic [MAX_BEATS-1:0][7:0] bytes;
    logic [BEAT_CNT_W-1:0]     count;
    logic                      tail;   // burst ends with the frame tail
  } scf_burst_t;

endpackage

`default_nettype wire

@@ design/serial_command_framer_top.sv @@
// serial_command_framer_top.sv: top level of the serial command framer.
// Depends on scf_pkg, scf_in_reg, scf_frame_ctl and scf_emitter.
//
// Channel  Handshake            Beat contents
// -------  -------------------  ---------------------------------------------
// input    in_valid / in_ready  req_type, cmd_code, payload_len, data_byte
// output   out_valid/out_ready  out_byte, frame_end (high on last tail byte)
//
// Each output beat carries one frame byte. A data beat inside a frame gives
// one byte (five when it closes the frame), a start beat six bytes (ten for
// an empty payload); the output shift register sends them one byte per cycle
// while out_ready is high. Dropped data beats outside a frame give nothing.
// The input register takes one beat while a burst still drains or stalls.
// Synchronous active-high reset: no frame open, both registers empty.
`timescale 1ns / 1ps
`default_nettype none

module serial_command_framer_top
  import scf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic [15:0] cmd_code,
  input  logic [8:0]  payload_len,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        frame_end
);

  scf_item_t  in_item;
  scf_item_t  item;
  logic       item_valid;
  logic       emit_free;
  logic       take;
  scf_burst_t burst;

  always_comb begin
    in_item.req_type    = req_type_t'(req_type);
    in_item.cmd_code    = cmd_code;
    in_item.payload_len = payload_len;
    in_item.data_byte   = data_byte;
  end

  // Registered beat moves on once the emitter is empty or drains this cycle.
  assign take = item_valid && emit_free;

  scf_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .item       (item),
    .item_valid (item_valid),
    .take       (take)
  );

  scf_frame_ctl u_frame_ctl (
    .clk   (clk),
    .rst   (rst),
    .item  (item),
    .take  (take),
    .burst (burst)
  );

  scf_emitter u_emitter (
    .clk       (clk),
    .rst       (rst),
    .burst     (burst),
    .load      (take),
    .free      (emit_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .frame_end (frame_end)
  );

endmodule

`default_nettype wire

@@ design/scf_in_reg.sv @@
// scf_in_reg.sv: one-entry input register of the framer.
// Depends on scf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module scf_in_reg
  import scf_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  scf_item_t in_item,
  output scf_item_t item,
  output logic      item_valid,
  input  logic      take
);

  logic full;

  assign in_ready   = !full || take;
  assign item_valid = full;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (in_ready) begin
      full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

`default_nettype wire

@@ design/scf_frame_ctl.sv @@
// scf_frame_ctl.sv: frame state and burst builder of the framer.
// Depends on scf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module scf_frame_ctl
  import scf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  scf_item_t  item,
  input  logic       take,
  output scf_burst_t burst
);

  logic        frame_open, frame_open_next;
  logic [8:0]  bytes_left, bytes_left_next;
  logic [15:0] running_sum, running_sum_next;

  logic [9:0]  total;
  logic [7:0]  len_hi, len_lo;
  logic [9:0]  start_sum;
  logic [15:0] start_sum16;
  logic [15:0] data_sum;
  logic [8:0]  left_dec;

  always_comb begin
    total       = {1'b0, item.payload_len} + FRAME_OVERHEAD;
    len_hi      = {6'b0, total[9:8]};
    len_lo      = total[7:0];
    start_sum   = {2'b0, len_hi} + {2'b0, len_lo}
                + {2'b0, item.cmd_code[15:8]} + {2'b0, item.cmd_code[7:0]};
    start_sum16 = {6'b0, start_sum};
    data_sum    = running_sum + {8'b0, item.data_byte};
    left_dec    = bytes_left - 9'd1;

    burst            = '0;
    frame_open_next  = frame_open;
    bytes_left_next  = bytes_left;
    running_sum_next = running_sum;

    unique case (item.req_type)
      REQ_START: begin
        burst.bytes[0] = HEAD0;
        burst.bytes[1] = HEAD1;
        burst.bytes[2] = len_hi;
        burst.bytes[3] = len_lo;
        burst.bytes[4] = item.cmd_code[15:8];
        burst.bytes[5] = item.cmd_code[7:0];
        if (item.payload_len == 9'd0) begin
          // empty payload: sum and tail follow the header at once
          burst.bytes[6]   = start_sum16[15:8];
          burst.bytes[7]   = start_sum16[7:0];
          burst.bytes[8]   = TAIL0;
          burst.bytes[9]   = TAIL1;
          burst.count      = BEAT_CNT_W'(10);
          burst.tail       = 1'b1;
          frame_open_next  = 1'b0;
          bytes_left_next  = 9'd0;
          running_sum_next = 16'd0;
        end else begin
          burst.count      = BEAT_CNT_W'(6);
          frame_open_next  = 1'b1;
          bytes_left_next  = item.payload_len;
          running_sum_next = start_sum16;
        end
      end
      REQ_DATA: begin
        if (frame_open) begin
          burst.bytes[0] = item.data_byte;
          if (left_dec == 9'd0) begin
            burst.bytes[1]   = data_sum[15:8];
            burst.bytes[2]   = data_sum[7:0];
            burst.bytes[3]   = TAIL0;
            burst.bytes[4]   = TAIL1;
            burst.count      = BEAT_CNT_W'(5);
            burst.tail       = 1'b1;
            frame_open_next  = 1'b0;
            bytes_left_next  = 9'd0;
            running_sum_next = 16'd0;
          end else begin
            burst.count      = BEAT_CNT_W'(1);
            bytes_left_next  = left_dec;
            running_sum_next = data_sum;
          end
        end
        // no open frame: byte dropped, empty burst
      end
      default: begin
        burst = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open  <= 1'b0;
      bytes_left  <= 9'd0;
      running_sum <= 16'd0;
    end else if (take) begin
      frame_open  <= frame_open_next;
      bytes_left  <= bytes_left_next;
      running_sum <= running_sum_next;
    end
  end

endmodule

`default_nettype wire

@@ design/scf_emitter.sv @@
// scf_emitter.sv: output shift register that sends a burst one byte per beat.
// Depends on scf_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module scf_emitter
  import scf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  scf_burst_t burst,
  input  logic       load,
  output logic       free,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       frame_end
);

  logic [MAX_BEATS-1:0][7:0] sh;
  logic [BEAT_CNT_W-1:0]     count;
  logic                      tail;
  logic                      last;

  assign last      = (count == BEAT_CNT_W'(1));
  assign free      = (count == '0) || (last && out_ready);
  assign out_valid = (count != '0);
  assign out_byte  = sh[0];
  assign frame_end = tail && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      tail  <= 1'b0;
    end else if (load) begin
      count <= burst.count;
      tail  <= burst.tail;
    end else if (out_valid && out_ready) begin
      count <= count - BEAT_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sh <= burst.bytes;
    end else if (out_valid && out_ready) begin
      sh <= {8'h00, sh[MAX_BEATS-1:1]};
    end
  end

  `SCF_CHECK(a_end_is_tail, clk, rst, frame_end |-> (out_byte == TAIL1), "frame end not on tail byte")
  `SCF_NEVER(a_count_bound, clk, rst, count > MAX_BEATS, "burst count out of range")
  `SCF_CHECK(a_load_count, clk, rst, load |=> (count == $past(burst.count)), "burst count lost on load")

endmodule

`default_nettype wire

@@ test/testbench.sv @@
// testbench.sv: self-checking bench for serial_command_framer_top.
// Queued input beats go through a randomized valid/ready driver, and an
// independent frame predictor checks every output byte. Needs scf_pkg.
`timescale 1ns / 1ps

module testbench;
  import scf_pkg::*;

  localparam int unsigned RUN_LIMIT   = 300000; // cycles before a timeout
  localparam int unsigned HOLD_AT     = 100;    // output beat that starts the long hold
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned SETTLE      = 30;     // quiet cycles after the last byte

  // One queued input beat, with its pre-offer gap and an optional drain wait.
  typedef struct {
    req_type_t   kind;
    logic [15:0] cmd;
    logic [8:0]  len;
    logic [7:0]  dat;
    int unsigned gap;
    bit          drain;
  } cmd_beat_t;

  typedef struct {
    logic [7:0] b;
    logic       last;
  } frame_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        req_type = 1'b0;
  logic [15:0] cmd_code = '0;
  logic [8:0]  payload_len = '0;
  logic [7:0]  data_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        frame_end;

  cmd_beat_t   beats_to_send[$];
  frame_byte_t frame_bytes_due[$];

  // Predictor state: the frame under construction.
  bit          frame_is_open = 1'b0;
  logic [8:0]  payload_left = '0;
  logic [15:0] frame_sum = '0;

  // Driver and receiver bookkeeping.
  cmd_beat_t   cur;
  bit          have_item = 1'b0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  logic        in_took = 1'b0;
  logic        out_took = 1'b0;
  int unsigned out_seen = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;

  // Stimulus shaping used while the queue is filled.
  bit          calm = 1'b0;
  bit          drain_next = 1'b0;

  serial_command_framer_top dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .cmd_code    (cmd_code),
    .payload_len (payload_len),
    .data_byte   (data_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .frame_end   (frame_end)
  );

  always #5 clk = ~clk;

  function automatic void due(logic [7:0] b, logic last);
    frame_byte_t fb;
    fb.b    = b;
    fb.last = last;
    frame_bytes_due.push_back(fb);
  endfunction

  // Checksum high/low, then the tail; the frame closes.
  function automatic void close_frame();
    due(frame_sum[15:8], 1'b0);
    due(frame_sum[7:0], 1'b0);
    due(TAIL0, 1'b0);
    due(TAIL1, 1'b1);
    frame_is_open = 1'b0;
    payload_left  = '0;
    frame_sum     = '0;
  endfunction

  // Frame bytes caused by one accepted input beat.
  function automatic void serialize_beat(req_type_t kind, logic [15:0] cmd,
                                         logic [8:0] len, logic [7:0] dat);
    logic [15:0] total;
    if (kind == REQ_START) begin
      // A start always wins: any open frame is dropped without sum or tail.
      total = 16'(len) + 16'(FRAME_OVERHEAD);
      due(HEAD0, 1'b0);
      due(HEAD1, 1'b0);
      due(total[15:8], 1'b0);
      due(total[7:0], 1'b0);
      due(cmd[15:8], 1'b0);
      due(cmd[7:0], 1'b0);
      frame_sum = 16'(total[15:8]) + 16'(total[7:0]) + 16'(cmd[15:8]) + 16'(cmd[7:0]);
      payload_left  = len;
      frame_is_open = 1'b1;
      if (len == 9'd0)
        close_frame();
    end else if (frame_is_open) begin
      due(dat, 1'b0);
      frame_sum    = frame_sum + 16'(dat);
      payload_left = payload_left - 9'd1;
      if (payload_left == 9'd0)
        close_frame();
    end
    // data outside a frame is dropped silently
  endfunction

  task automatic queue_beat(req_type_t kind, logic [15:0] cmd, logic [8:0] len,
                            logic [7:0] dat);
    cmd_beat_t cb;
    cb.kind  = kind;
    cb.cmd   = cmd;
    cb.len   = len;
    cb.dat   = dat;
    cb.gap   = calm ? 0 : $urandom_range(0, 11);
    cb.drain = drain_next;
    drain_next = 1'b0;
    beats_to_send.push_back(cb);
  endtask

  // Unused fields carry random junk so the block must ignore them.
  task automatic queue_start(logic [15:0] cmd, logic [8:0] len);
    queue_beat(REQ_START, cmd, len, 8'($urandom));
  endtask

  task automatic queue_data(logic [7:0] dat);
    queue_beat(REQ_DATA, 16'($urandom), 9'($urandom), dat);
  endtask

  // Input driver: one beat at a time from the queue, changes on the falling edge.
  always @(negedge clk) begin : drive_in
    logic valid_n;
    valid_n = in_valid;
    if (rst) begin
      valid_n = 1'b0;
    end else begin
      if (in_valid && in_took)
        valid_n = 1'b0;
      if (!valid_n && !have_item && beats_to_send.size() != 0) begin
        cur       = beats_to_send.pop_front();
        have_item = 1'b1;
        gap_left  = cur.gap;
      end
      if (!valid_n && have_item) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (!cur.drain || frame_bytes_due.size() == 0) begin
          valid_n     = 1'b1;
          have_item   = 1'b0;
          req_type    <= cur.kind;
          cmd_code    <= cur.cmd;
          payload_len <= cur.len;
          data_byte   <= cur.dat;
        end
      end
    end
    in_valid <= valid_n;
  end

  // Output receiver: random stall after each beat, quiet stretches, one long hold.
  always @(negedge clk) begin : drive_out
    logic ready_n;
    ready_n = out_ready;
    if (rst) begin
      ready_n = 1'b0;
    end else begin
      if (out_ready && out_took) begin
        ready_n = 1'b0;
        if (out_seen == HOLD_AT)
          stall_left = HOLD_CYCLES;
        else if (((out_seen >> 6) % 4) == 3)
          stall_left = 0;
        else
          stall_left = $urandom_range(0, 11);
      end
      if (!ready_n) begin
        if (stall_left != 0)
          stall_left--;
        else
          ready_n = 1'b1;
      end
    end
    out_ready <= ready_n;
  end

  // Monitor: predict on input beats, compare on output beats.
  always @(posedge clk) begin : watch
    frame_byte_t want;
    in_took  <= !rst && in_valid && in_ready;
    out_took <= !rst && out_valid && out_ready;
    if (!rst && in_valid && in_ready)
      serialize_beat(req_type_t'(req_type), cmd_code, payload_len, data_byte);
    if (!rst && out_valid && out_ready) begin
      out_seen++;
      if (frame_bytes_due.size() == 0) begin
        $display("%0t: unexpected beat, expected none, got out_byte=%02h frame_end=%0b",
                 $time, out_byte, frame_end);
        mismatches++;
      end else begin
        want = frame_bytes_due.pop_front();
        if (out_byte !== want.b) begin
          $display("%0t: out_byte expected %02h, got %02h", $time, want.b, out_byte);
          mismatches++;
        end
        if (frame_end !== want.last) begin
          $display("%0t: frame_end expected %0b, got %0b", $time, want.last, frame_end);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycles <= cycles + 1;
    if (cycles > RUN_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned counted;
    int unsigned len;
    int unsigned n;

    // Directed: dropped data, empty payloads, field extremes, abandoned frames.
    queue_beat(REQ_DATA, 16'hFFFF, 9'h1FF, 8'hFF);
    queue_beat(REQ_START, 16'hFFFF, 9'd0, 8'hFF);
    queue_beat(REQ_START, 16'h0000, 9'd0, 8'h00);
    queue_start(16'h1234, 9'd2);
    queue_data(8'h00);
    queue_data(8'hFF);
    queue_data(8'h5A);
    queue_start(16'hABCD, 9'd3);
    queue_data(8'h80);
    queue_start(16'h8001, 9'd1);
    queue_data(8'h7F);
    queue_start(16'h00FF, 9'd256);
    queue_data(8'h01);
    queue_data(8'h02);
    queue_data(8'h03);
    queue_start(16'hFF00, 9'd470);
    queue_data(8'hAA);
    queue_start(16'h5A5A, 9'd1);
    queue_data(8'h3C);

    // Largest length field, cut short by the next start; the long output hold lands here.
    drain_next = 1'b1;
    queue_start(16'hC3C3, 9'd511);
    for (int i = 0; i < 40; i++)
      queue_data(($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'hFF);

    // Random frames: mostly complete, some cut short, some stray data between.
    drain_next = 1'b1;
    counted = 0;
    while (counted < 60) begin
      calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 5) == 0)
        queue_data(8'($urandom));
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511) : $urandom_range(0, 8);
      queue_start(16'($urandom), 9'(len));
      counted++;
      if (len > 40)
        n = $urandom_range(0, 6);
      else if ($urandom_range(0, 7) == 0)
        n = $urandom_range(0, len);
      else
        n = len;
      for (int i = 0; i < n; i++) begin
        queue_data(8'($urandom));
        counted++;
      end
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (beats_to_send.size() != 0 || have_item || in_valid)
      @(posedge clk);
    while (frame_bytes_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ serial_command_framer_top.f @@
+incdir+design
design/scf_pkg.sv
design/scf_in_reg.sv
design/scf_frame_ctl.sv
design/scf_emitter.sv
design/serial_command_framer_top.sv
test/testbench.sv
